### hw/rtl/mcg_pkg.sv
// shared types and constants of the midi clock generator
`default_nettype none

package mcg_pkg;

    localparam int TICK_W           = 32;
    localparam int PPQN_W           = 15;
    localparam int MODE_W           = 2;
    localparam int OP_W             = 3;
    localparam int KIND_W           = 2;
    localparam int CFG_IDX_W        = 2;

    localparam int ALIGN_SIXTEENTHS = 64;
    localparam int MAX_PULSES       = 64;
    localparam int CNT_W            = $clog2(MAX_PULSES + 1);

    // ticks per sixteenth is ppqn / 4
    localparam int UNIT_W           = PPQN_W - 2;
    localparam int DVSR_W           = UNIT_W + $clog2(ALIGN_SIXTEENTHS + 1);

    // ppqn / 24 as ((ppqn >> 3) * DIV3_RECIP) >> DIV3_SHIFT, exact for 12-bit operands
    localparam int DIV3_IN_W        = PPQN_W - 3;
    localparam int DIV3_RECIP       = 2731;
    localparam int DIV3_SHIFT       = 13;
    localparam int DIV3_PROD_W      = DIV3_IN_W + 12;
    localparam int CT_W             = DIV3_PROD_W - DIV3_SHIFT;

    localparam logic [OP_W-1:0] OP_INIT     = 3'd0;
    localparam logic [OP_W-1:0] OP_CONTINUE = 3'd1;
    localparam logic [OP_W-1:0] OP_START    = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP     = 3'd3;
    localparam logic [OP_W-1:0] OP_ADVANCE  = 3'd4;

    localparam logic [KIND_W-1:0] KIND_START    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_STOP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONTINUE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLOCK    = 2'd3;

    localparam logic [MODE_W-1:0] MODE_OFF      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POS      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MOD      = 2'd2;
    localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_PPQN       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOCK_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_ON    = 2'd2;

    localparam logic [PPQN_W-1:0] PPQN_RESET = 15'd192;

    typedef struct packed {
        logic [PPQN_W-1:0] ppqn;
        logic [MODE_W-1:0] clock_mode;
        logic              port_on;
    } cfg_t;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TICK_W-1:0] quotient;
        logic [DVSR_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/mcg_divider.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none

module mcg_divider
(
    input  wire               clk,
    input  wire               rst_n,
    input  mcg_pkg::div_req_t req,
    output mcg_pkg::div_rsp_t rsp
);

    localparam int STEP_W = $clog2(mcg_pkg::TICK_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [mcg_pkg::TICK_W-1:0]  quot_reg, quot_next;
    logic [mcg_pkg::DVSR_W-1:0]  rem_reg, rem_next;
    logic [mcg_pkg::DVSR_W-1:0]  dvsr_reg, dvsr_next;
    logic [mcg_pkg::DVSR_W:0]    rem_sh;
    logic                        fits;

    assign rem_sh = {rem_reg, quot_reg[mcg_pkg::TICK_W-1]};
    assign fits   = rem_sh >= {1'b0, dvsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quot_next = req.dividend;
            rem_next  = '0;
            dvsr_next = req.divisor;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[mcg_pkg::TICK_W-2:0], fits};
            rem_next  = fits ? mcg_pkg::DVSR_W'(rem_sh - {1'b0, dvsr_reg})
                             : mcg_pkg::DVSR_W'(rem_sh);
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(mcg_pkg::TICK_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

### hw/rtl/mcg_ctrl.sv
// transport sequencer: opcode decode, tick state, pulse runs and output register
`default_nettype none

module mcg_ctrl
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  mcg_pkg::cfg_t                     cfg,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire  [mcg_pkg::OP_W-1:0]          in_opcode,
    input  wire  [mcg_pkg::TICK_W-1:0]        in_tick,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [mcg_pkg::KIND_W-1:0]        out_kind,
    output logic [mcg_pkg::TICK_W-1:0]        out_position,
    output logic                              out_last,
    output logic                              out_dropped,
    output mcg_pkg::div_req_t                 div_req,
    input  mcg_pkg::div_rsp_t                 div_rsp
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV_CONT = 3'd1;
    localparam logic [2:0] ST_DIV_INIT = 3'd2;
    localparam logic [2:0] ST_DIV_A1   = 3'd3;
    localparam logic [2:0] ST_DIV_A2   = 3'd4;
    localparam logic [2:0] ST_EMIT     = 3'd5;

    localparam int LAST_W = mcg_pkg::TICK_W + 1;
    localparam logic [LAST_W-1:0] LAST_NONE = '1;
    localparam logic [LAST_W-1:0] LAST_MAX  = {1'b0, {mcg_pkg::TICK_W{1'b1}}};

    logic [2:0]                       state_reg, state_next;
    logic [LAST_W-1:0]                last_tick_reg, last_tick_next;
    logic [mcg_pkg::TICK_W-1:0]       tick_reg, tick_next;
    logic [mcg_pkg::DVSR_W-1:0]       rnd_unit_reg, rnd_unit_next;
    logic [mcg_pkg::DVSR_W-1:0]       ct_reg, ct_next;
    logic [mcg_pkg::TICK_W-1:0]       q1_reg, q1_next;
    logic [mcg_pkg::KIND_W-1:0]       kind_reg, kind_next;
    logic [mcg_pkg::TICK_W-1:0]       pos_reg, pos_next;
    logic [mcg_pkg::CNT_W-1:0]        remaining_reg, remaining_next;
    logic                             drop_reg, drop_next;

    logic                             out_valid_reg, out_valid_next;
    logic [mcg_pkg::KIND_W-1:0]       out_kind_reg;
    logic [mcg_pkg::TICK_W-1:0]       out_pos_reg;
    logic                             out_last_reg;
    logic                             out_drop_reg;

    logic                             clock_on;
    logic                             in_fire;
    logic                             slot_free;
    logic [mcg_pkg::UNIT_W-1:0]       unit_raw;
    logic [mcg_pkg::DVSR_W-1:0]       unit;
    logic [mcg_pkg::DVSR_W-1:0]       unit_align;
    logic [mcg_pkg::DIV3_PROD_W-1:0]  div3_prod;
    logic [mcg_pkg::CT_W-1:0]         ct_raw;
    logic [mcg_pkg::DVSR_W-1:0]       ct;
    logic                             tick_after_last;
    logic [LAST_W-1:0]                rounded;
    logic [LAST_W-1:0]                run_count;
    logic                             run_load;

    function automatic logic [LAST_W-1:0] round_up_less_one(
        input logic [mcg_pkg::TICK_W-1:0] tick,
        input logic [mcg_pkg::DVSR_W-1:0] rem,
        input logic [mcg_pkg::DVSR_W-1:0] step
    );
        logic [LAST_W-1:0] t;
        t = {1'b0, tick} - LAST_W'(rem) + ((rem != '0) ? LAST_W'(step) : '0);
        if (t == '0)
            return LAST_NONE;
        else if (t[LAST_W-1])
            return LAST_MAX;
        else
            return t - LAST_W'(1);
    endfunction

    assign clock_on = (cfg.clock_mode == mcg_pkg::MODE_POS)
                   || (cfg.clock_mode == mcg_pkg::MODE_MOD);

    assign unit_raw   = cfg.ppqn[mcg_pkg::PPQN_W-1:2];
    assign unit       = (unit_raw == '0) ? mcg_pkg::DVSR_W'(1) : mcg_pkg::DVSR_W'(unit_raw);
    assign unit_align = mcg_pkg::DVSR_W'(unit * mcg_pkg::DVSR_W'(mcg_pkg::ALIGN_SIXTEENTHS));

    assign div3_prod = mcg_pkg::DIV3_PROD_W'(cfg.ppqn[mcg_pkg::PPQN_W-1:3])
                     * mcg_pkg::DIV3_PROD_W'(mcg_pkg::DIV3_RECIP);
    assign ct_raw    = div3_prod[mcg_pkg::DIV3_PROD_W-1:mcg_pkg::DIV3_SHIFT];
    assign ct        = (ct_raw == '0) ? mcg_pkg::DVSR_W'(1) : mcg_pkg::DVSR_W'(ct_raw);

    assign tick_after_last = $signed({1'b0, in_tick}) > $signed(last_tick_reg);
    assign rounded         = round_up_less_one(tick_reg, div_rsp.remainder, rnd_unit_reg);

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        last_tick_next = last_tick_reg;
        tick_next      = tick_reg;
        rnd_unit_next  = rnd_unit_reg;
        ct_next        = ct_reg;
        q1_next        = q1_reg;
        kind_next      = kind_reg;
        pos_next       = pos_reg;
        remaining_next = remaining_reg;
        drop_next      = drop_reg;
        div_req.start    = 1'b0;
        div_req.dividend = in_tick;
        div_req.divisor  = unit;
        run_load  = 1'b0;
        run_count = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    tick_next = in_tick;
                    unique case (in_opcode)
                        mcg_pkg::OP_INIT:
                        begin
                            if (cfg.port_on && cfg.ppqn != '0)
                            begin
                                if (cfg.clock_mode == mcg_pkg::MODE_POS && in_tick != '0)
                                begin
                                    div_req.start = 1'b1;
                                    rnd_unit_next = unit;
                                    state_next    = ST_DIV_CONT;
                                end
                                else if (cfg.clock_mode == mcg_pkg::MODE_MOD || in_tick == '0)
                                begin
                                    div_req.start   = 1'b1;
                                    div_req.divisor = unit_align;
                                    rnd_unit_next   = unit_align;
                                    state_next      = ST_DIV_INIT;
                                end
                            end
                        end
                        mcg_pkg::OP_CONTINUE:
                        begin
                            div_req.start = 1'b1;
                            rnd_unit_next = unit;
                            state_next    = ST_DIV_CONT;
                        end
                        mcg_pkg::OP_START, mcg_pkg::OP_STOP:
                        begin
                            last_tick_next = LAST_NONE;
                            if (clock_on)
                            begin
                                kind_next      = (in_opcode == mcg_pkg::OP_START)
                                               ? mcg_pkg::KIND_START : mcg_pkg::KIND_STOP;
                                pos_next       = '0;
                                remaining_next = mcg_pkg::CNT_W'(1);
                                drop_next      = 1'b0;
                                state_next     = ST_EMIT;
                            end
                        end
                        mcg_pkg::OP_ADVANCE:
                        begin
                            if (clock_on && tick_after_last)
                            begin
                                div_req.start   = 1'b1;
                                div_req.divisor = ct;
                                ct_next         = ct;
                                state_next      = ST_DIV_A1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DIV_CONT, ST_DIV_INIT:
            begin
                if (div_rsp.done)
                begin
                    last_tick_next = rounded;
                    if (clock_on)
                    begin
                        kind_next      = (state_reg == ST_DIV_CONT)
                                       ? mcg_pkg::KIND_CONTINUE : mcg_pkg::KIND_START;
                        pos_next       = (state_reg == ST_DIV_CONT) ? div_rsp.quotient : '0;
                        remaining_next = mcg_pkg::CNT_W'(1);
                        drop_next      = 1'b0;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV_A1:
            begin
                if (div_rsp.done)
                begin
                    q1_next        = div_rsp.quotient;
                    last_tick_next = {1'b0, tick_reg};
                    if (last_tick_reg[LAST_W-1])
                    begin
                        run_load  = 1'b1;
                        run_count = {1'b0, div_rsp.quotient} + LAST_W'(1);
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = last_tick_reg[mcg_pkg::TICK_W-1:0];
                        div_req.divisor  = ct_reg;
                        state_next       = ST_DIV_A2;
                    end
                end
            end
            ST_DIV_A2:
            begin
                if (div_rsp.done)
                begin
                    run_load  = 1'b1;
                    run_count = {1'b0, q1_reg} - {1'b0, div_rsp.quotient};
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    remaining_next = remaining_reg - mcg_pkg::CNT_W'(1);
                    if (remaining_reg == mcg_pkg::CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (run_load)
        begin
            kind_next = mcg_pkg::KIND_CLOCK;
            pos_next  = tick_reg;
            priority if (run_count == '0)
            begin
                state_next = ST_IDLE;
            end
            else if (run_count > LAST_W'(mcg_pkg::MAX_PULSES))
            begin
                remaining_next = mcg_pkg::CNT_W'(mcg_pkg::MAX_PULSES);
                drop_next      = 1'b1;
                state_next     = ST_EMIT;
            end
            else
            begin
                remaining_next = run_count[mcg_pkg::CNT_W-1:0];
                drop_next      = 1'b0;
                state_next     = ST_EMIT;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (slot_free)
            out_valid_next = (state_reg == ST_EMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_tick_reg <= '0;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_tick_reg <= last_tick_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg     <= tick_next;
        rnd_unit_reg <= rnd_unit_next;
        ct_reg       <= ct_next;
        q1_reg       <= q1_next;
        kind_reg     <= kind_next;
        pos_reg      <= pos_next;
        drop_reg     <= drop_next;
        if (state_reg == ST_EMIT && slot_free)
        begin
            out_kind_reg <= kind_reg;
            out_pos_reg  <= pos_reg;
            out_last_reg <= (remaining_reg == mcg_pkg::CNT_W'(1));
            out_drop_reg <= (remaining_reg == mcg_pkg::CNT_W'(1)) && drop_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_position = out_pos_reg;
    assign out_last     = out_last_reg;
    assign out_dropped  = out_drop_reg;

    // only -1 may appear as a negative tick
    a_last_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
        last_tick_reg[LAST_W-1] |-> (last_tick_reg == LAST_NONE))
        else $error("last clocked tick holds a negative value other than -1");

    a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_rsp.busy)
        else $error("sequencer idle while the divider is still running");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |->
            (remaining_reg != '0) && (remaining_reg <= mcg_pkg::CNT_W'(mcg_pkg::MAX_PULSES)))
        else $error("pulse run count out of range");

    a_drop_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_drop_reg) |-> (out_last_reg && out_kind_reg == mcg_pkg::KIND_CLOCK))
        else $error("dropped flag on a result that does not end a pulse run");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> $past(div_rsp.busy))
        else $error("divider finished without running");

endmodule

`default_nettype wire

### hw/rtl/midi_clock_generator_unit.sv
// top level of the midi clock generator: configuration registers, sequencer and divider
// start and stop pass through the emit state into the output register if the clock is on
// continue runs one 32-step division in the shared divider, init runs at most one
// advance, when taken, runs one or two divisions before its run of up to 64 pulses
// pulses leave one per cycle while the output side is ready; a new input waits until done
// reset: ppqn 192, clock mode off, port on, last clocked tick zero, no transaction pending
`default_nettype none

module midi_clock_generator_unit
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire  [mcg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [mcg_pkg::PPQN_W-1:0]         cfg_data,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [mcg_pkg::TICK_W-1:0]         s_axis_tdata,   // tick_pos
    input  wire  [mcg_pkg::OP_W-1:0]           s_axis_tuser,   // opcode
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [mcg_pkg::TICK_W-1:0]         m_axis_tdata,   // position
    output logic [mcg_pkg::KIND_W:0]           m_axis_tuser,   // message_kind, pulses_dropped
    output logic                               m_axis_tlast
);

    logic [mcg_pkg::PPQN_W-1:0] ppqn_reg, ppqn_next;
    logic [mcg_pkg::MODE_W-1:0] clock_mode_reg, clock_mode_next;
    logic                       port_on_reg, port_on_next;

    mcg_pkg::cfg_t              cfg;
    mcg_pkg::div_req_t          div_req;
    mcg_pkg::div_rsp_t          div_rsp;
    logic [mcg_pkg::KIND_W-1:0] out_kind;
    logic                       out_dropped;

    always_comb
    begin
        ppqn_next       = ppqn_reg;
        clock_mode_next = clock_mode_reg;
        port_on_next    = port_on_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                mcg_pkg::REG_PPQN:       ppqn_next       = cfg_data;
                mcg_pkg::REG_CLOCK_MODE: clock_mode_next = cfg_data[mcg_pkg::MODE_W-1:0];
                mcg_pkg::REG_PORT_ON:    port_on_next    = cfg_data[0];
                default:                 ppqn_next       = ppqn_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppqn_reg       <= mcg_pkg::PPQN_RESET;
            clock_mode_reg <= mcg_pkg::MODE_OFF;
            port_on_reg    <= 1'b1;
        end
        else
        begin
            ppqn_reg       <= ppqn_next;
            clock_mode_reg <= clock_mode_next;
            port_on_reg    <= port_on_next;
        end
    end

    assign cfg.ppqn       = ppqn_reg;
    assign cfg.clock_mode = clock_mode_reg;
    assign cfg.port_on    = port_on_reg;

    mcg_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mcg_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_opcode    (s_axis_tuser),
        .in_tick      (s_axis_tdata),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_kind     (out_kind),
        .out_position (m_axis_tdata),
        .out_last     (m_axis_tlast),
        .out_dropped  (out_dropped),
        .div_req      (div_req),
        .div_rsp      (div_rsp)
    );

    assign m_axis_tuser = {out_dropped, out_kind};

endmodule

`default_nettype wire
